// ===== rtl/mr3k_pkg.sv =====
`default_nettype none

package mr3k_pkg;

  localparam int GPR_COUNT_DEFAULT = 32;
  localparam int C0_COUNT = 32;

  localparam logic [31:0] PC_RESET       = 32'hBFC0_0000;
  localparam logic [31:0] SP_RESET_VALUE = 32'h801F_FFF0;
  localparam logic [31:0] C0_STATUS_INIT = 32'h1040_0000;
  localparam logic [31:0] C0_PRID_INIT   = 32'h0000_0002;
  localparam logic [31:0] CAUSE_WR_MASK  = 32'h0000_0300;
  localparam logic [31:0] JUMP_REGION    = 32'hF000_0000;

  localparam logic [4:0] GPR_ZERO = 5'd0;
  localparam logic [4:0] REG_SP   = 5'd29;
  localparam logic [4:0] REG_RA   = 5'd31;

  localparam logic [4:0] C0_BADVADDR = 5'd8;
  localparam logic [4:0] C0_R6       = 5'd6;
  localparam logic [4:0] C0_SR       = 5'd12;
  localparam logic [4:0] C0_CAUSE    = 5'd13;
  localparam logic [4:0] C0_EPC      = 5'd14;
  localparam logic [4:0] C0_PRID     = 5'd15;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNIMPL  = 2'd1;
  localparam logic [1:0] ST_NO_BOOT = 2'd2;
  localparam logic [1:0] ST_KIND    = 2'd3;

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // SPECIAL function codes.
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  // COP0 rs codes and the RFE function code.
  localparam logic [4:0] CO_MF  = 5'h00;
  localparam logic [4:0] CO_MT  = 5'h04;
  localparam logic [4:0] CO_CO  = 5'h10;
  localparam logic [5:0] FN_RFE = 6'h10;

  typedef struct packed {
    logic start;
    logic is_div;
    logic is_signed;
  } md_req_t;

  function automatic logic [31:0] c0_reset_value(input logic [4:0] addr);
    logic [31:0] v;
    v = '0;
    if (addr == C0_SR) v = C0_STATUS_INIT;
    if (addr == C0_PRID) v = C0_PRID_INIT;
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mr3k_ram.sv =====
`default_nettype none

module mr3k_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mr3k_muldiv.sv =====
`default_nettype none

module mr3k_muldiv (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mr3k_pkg::md_req_t req,
  input  wire logic [31:0]      a,
  input  wire logic [31:0]      b,
  output logic                  done,
  output logic      [31:0]      hi,
  output logic      [31:0]      lo
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_RUN  = 2'd1;
  localparam logic [1:0] P_FIX  = 2'd2;

  logic [1:0]  phase;
  logic [4:0]  cnt;
  logic        is_div;
  logic        is_sgn;
  logic        special;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [31:0] dvs;
  logic [31:0] acc_hi;
  logic [31:0] acc_lo;
  logic [32:0] mul_sum;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        a_neg;
  logic        b_neg;
  logic [31:0] corr_a;
  logic [31:0] corr_b;

  assign a_neg   = is_sgn & opa[31];
  assign b_neg   = is_sgn & opb[31];
  assign mul_sum = {1'b0, acc_hi} + (acc_lo[0] ? {1'b0, dvs} : 33'd0);
  assign rem_sh  = {acc_hi, acc_lo[31]};
  assign diff    = rem_sh - {1'b0, dvs};
  assign corr_a  = a_neg ? opb : 32'd0;
  assign corr_b  = b_neg ? opa : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (req.start) begin
            phase <= P_RUN;
          end
        end
        P_RUN: begin
          if (special || cnt == 5'd0) begin
            phase <= P_FIX;
          end
        end
        P_FIX: begin
          phase <= P_IDLE;
          done  <= 1'b1;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == P_IDLE && req.start) begin
      opa     <= a;
      opb     <= b;
      is_div  <= req.is_div;
      is_sgn  <= req.is_signed;
      cnt     <= 5'd31;
      acc_hi  <= '0;
      special <= 1'b0;
      if (req.is_div) begin
        dvs    <= (req.is_signed && b[31]) ? (32'd0 - b) : b;
        acc_lo <= (req.is_signed && a[31]) ? (32'd0 - a) : a;
        if (b == 32'd0) begin
          special <= 1'b1;
          acc_hi  <= a;
          acc_lo  <= (req.is_signed && a[31]) ? 32'd1 : 32'hFFFF_FFFF;
        end else if (req.is_signed && a == 32'h8000_0000 && b == 32'hFFFF_FFFF) begin
          special <= 1'b1;
          acc_hi  <= 32'd0;
          acc_lo  <= 32'h8000_0000;
        end
      end else begin
        dvs    <= a;
        acc_lo <= b;
      end
    end else if (phase == P_RUN && !special) begin
      cnt <= cnt - 5'd1;
      if (is_div) begin
        // One restoring step: shift in the next dividend bit, subtract if it fits.
        if (!diff[32]) begin
          acc_hi <= diff[31:0];
        end else begin
          acc_hi <= rem_sh[31:0];
        end
        acc_lo <= {acc_lo[30:0], ~diff[32]};
      end else begin
        acc_hi <= mul_sum[32:1];
        acc_lo <= {mul_sum[0], acc_lo[31:1]};
      end
    end else if (phase == P_FIX) begin
      if (special) begin
        hi <= acc_hi;
        lo <= acc_lo;
      end else if (is_div) begin
        lo <= (a_neg != b_neg) ? (32'd0 - acc_lo) : acc_lo;
        hi <= a_neg ? (32'd0 - acc_hi) : acc_hi;
      end else begin
        // Signed product from the unsigned one by correcting the upper word.
        hi <= acc_hi - corr_a - corr_b;
        lo <= acc_lo;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mips_r3000_instruction_execute.sv =====
`default_nettype none
// An accepted instruction has its registers read, then executes and writes back, and its
// result then enters the output register; load data and refused transactions go straight
// to the output register. MULT/MULTU/DIV/DIVU wait for the one-bit-per-cycle multiply/divide
// unit, which skips the bit steps for a divide by zero or the overflowing signed divide.
// A new transaction is taken only once the last one has moved to the output register; a result
// still waiting in the output register holds the next one back. Reset (rst, synchronous, active
// high) sets PC to 0xBFC00000, clears HI/LO and pending load, and marks every register file
// entry as holding its reset value; no clearing pass is needed.

module mips_r3000_instruction_execute #(
  parameter int GPR_COUNT = mr3k_pkg::GPR_COUNT_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [31:0] instr_word,
  input  wire logic [31:0] load_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [1:0]  status,
  output logic      [31:0] fetch_pc,
  output logic             mem_read,
  output logic             mem_write,
  output logic      [31:0] mem_addr,
  output logic      [31:0] mem_wdata
);

  localparam int AW = $clog2(GPR_COUNT);
  localparam int CW = $clog2(mr3k_pkg::C0_COUNT);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MD   = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]  state;
  logic        boot_image_present;
  logic [31:0] pc;
  logic [31:0] npc;
  logic [31:0] hi;
  logic [31:0] lo;
  logic        load_pending;
  logic [AW-1:0] load_dest;
  logic [63:0] retired_count;
  logic [31:0] instr;

  // A register file entry that was never written since reset reads as its reset value.
  logic [GPR_COUNT-1:0]            gpr_valid;
  logic [mr3k_pkg::C0_COUNT-1:0]   c0_valid;

  logic [AW-1:0] rs_r;
  logic [AW-1:0] rt_r;
  logic [CW-1:0] c0_addr;
  logic [31:0]   gpr_q_s;
  logic [31:0]   gpr_q_t;
  logic [31:0]   c0_q;

  // Staged result, moved into the output register in S_DONE.
  logic [1:0]  res_status;
  logic [31:0] res_pc;
  logic        res_rd;
  logic        res_wr;
  logic [31:0] res_addr;
  logic [31:0] res_wdata;

  logic accept;
  logic load_done;
  assign accept    = in_valid & in_ready;
  assign in_ready  = (state == S_IDLE);
  assign load_done = accept & boot_image_present & kind & load_pending;

  logic [4:0] in_rs;
  logic [4:0] in_rd;
  assign in_rs = instr_word[25:21];
  assign in_rd = instr_word[15:11];

  // Execute-stage decode.
  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] s;
  logic [31:0] t;
  logic [31:0] c0v;
  logic [31:0] pc_n;
  logic [31:0] npc_n;
  logic [31:0] jt;
  logic [31:0] ea;

  assign op   = instr[31:26];
  assign fn   = instr[5:0];
  assign rs   = instr[25:21];
  assign rt   = instr[20:16];
  assign rd   = instr[15:11];
  assign sh   = instr[10:6];
  assign imm  = {16'd0, instr[15:0]};
  assign simm = {{16{instr[15]}}, instr[15:0]};
  assign pc_n = npc;
  assign jt   = (pc_n & mr3k_pkg::JUMP_REGION) | {4'd0, instr[25:0], 2'b00};
  assign ea   = s + simm;

  always_comb begin
    if (rs_r == AW'(mr3k_pkg::GPR_ZERO)) begin
      s = '0;
    end else if (gpr_valid[rs_r]) begin
      s = gpr_q_s;
    end else begin
      s = (rs_r == AW'(mr3k_pkg::REG_SP)) ? mr3k_pkg::SP_RESET_VALUE : 32'd0;
    end
    if (rt_r == AW'(mr3k_pkg::GPR_ZERO)) begin
      t = '0;
    end else if (gpr_valid[rt_r]) begin
      t = gpr_q_t;
    end else begin
      t = (rt_r == AW'(mr3k_pkg::REG_SP)) ? mr3k_pkg::SP_RESET_VALUE : 32'd0;
    end
    c0v = c0_valid[c0_addr] ? c0_q : mr3k_pkg::c0_reset_value(c0_addr);
  end

  logic          ex_status_unimpl;
  logic          wb_en;
  logic [4:0]    wb_addr;
  logic [31:0]   wb_data;
  logic          c0_we_ex;
  logic [31:0]   c0_wdata_ex;
  logic          hi_we;
  logic          lo_we;
  logic          md_go;
  logic          md_div;
  logic          md_sgn;
  logic          ex_rd;
  logic          ex_wr;
  logic [31:0]   ex_addr;
  logic [31:0]   ex_wdata;

  always_comb begin
    ex_status_unimpl = 1'b0;
    wb_en       = 1'b0;
    wb_addr     = rd;
    wb_data     = '0;
    c0_we_ex    = 1'b0;
    c0_wdata_ex = t;
    hi_we       = 1'b0;
    lo_we       = 1'b0;
    md_go       = 1'b0;
    md_div      = 1'b0;
    md_sgn      = 1'b0;
    ex_rd       = 1'b0;
    ex_wr       = 1'b0;
    ex_addr     = '0;
    ex_wdata    = '0;
    npc_n       = pc_n + 32'd4;
    unique case (op)
      mr3k_pkg::OP_SPECIAL: begin
        wb_en = 1'b1;
        unique case (fn)
          mr3k_pkg::FN_SLL:   wb_data = t << sh;
          mr3k_pkg::FN_SRL:   wb_data = t >> sh;
          mr3k_pkg::FN_SRA:   wb_data = 32'($signed(t) >>> sh);
          mr3k_pkg::FN_SLLV:  wb_data = t << s[4:0];
          mr3k_pkg::FN_SRLV:  wb_data = t >> s[4:0];
          mr3k_pkg::FN_SRAV:  wb_data = 32'($signed(t) >>> s[4:0]);
          mr3k_pkg::FN_JR: begin
            wb_en = 1'b0;
            npc_n = s;
          end
          mr3k_pkg::FN_JALR: begin
            wb_data = pc_n + 32'd4;
            npc_n   = s;
          end
          mr3k_pkg::FN_MFHI:  wb_data = hi;
          mr3k_pkg::FN_MTHI: begin
            wb_en = 1'b0;
            hi_we = 1'b1;
          end
          mr3k_pkg::FN_MFLO:  wb_data = lo;
          mr3k_pkg::FN_MTLO: begin
            wb_en = 1'b0;
            lo_we = 1'b1;
          end
          mr3k_pkg::FN_MULT, mr3k_pkg::FN_MULTU,
          mr3k_pkg::FN_DIV, mr3k_pkg::FN_DIVU: begin
            wb_en  = 1'b0;
            md_go  = 1'b1;
            md_div = fn[1];
            md_sgn = ~fn[0];
          end
          mr3k_pkg::FN_ADD, mr3k_pkg::FN_ADDU: wb_data = s + t;
          mr3k_pkg::FN_SUB, mr3k_pkg::FN_SUBU: wb_data = s - t;
          mr3k_pkg::FN_AND:   wb_data = s & t;
          mr3k_pkg::FN_OR:    wb_data = s | t;
          mr3k_pkg::FN_XOR:   wb_data = s ^ t;
          mr3k_pkg::FN_NOR:   wb_data = ~(s | t);
          mr3k_pkg::FN_SLT:   wb_data = {31'd0, $signed(s) < $signed(t)};
          mr3k_pkg::FN_SLTU:  wb_data = {31'd0, s < t};
          default: begin
            wb_en = 1'b0;
            ex_status_unimpl = 1'b1;
          end
        endcase
      end
      mr3k_pkg::OP_J: npc_n = jt;
      mr3k_pkg::OP_JAL: begin
        wb_en   = 1'b1;
        wb_addr = mr3k_pkg::REG_RA;
        wb_data = pc_n + 32'd4;
        npc_n   = jt;
      end
      mr3k_pkg::OP_BEQ, mr3k_pkg::OP_BNE: begin
        if ((s == t) == (op == mr3k_pkg::OP_BEQ)) begin
          npc_n = pc_n + {simm[29:0], 2'b00};
        end
      end
      mr3k_pkg::OP_ADDI, mr3k_pkg::OP_ADDIU: begin
        wb_en = 1'b1; wb_addr = rt; wb_data = s + simm;
      end
      mr3k_pkg::OP_SLTI: begin
        wb_en = 1'b1; wb_addr = rt; wb_data = {31'd0, $signed(s) < $signed(simm)};
      end
      mr3k_pkg::OP_SLTIU: begin
        wb_en = 1'b1; wb_addr = rt; wb_data = {31'd0, s < simm};
      end
      mr3k_pkg::OP_ANDI: begin
        wb_en = 1'b1; wb_addr = rt; wb_data = s & imm;
      end
      mr3k_pkg::OP_ORI: begin
        wb_en = 1'b1; wb_addr = rt; wb_data = s | imm;
      end
      mr3k_pkg::OP_XORI: begin
        wb_en = 1'b1; wb_addr = rt; wb_data = s ^ imm;
      end
      mr3k_pkg::OP_LUI: begin
        wb_en = 1'b1; wb_addr = rt; wb_data = {instr[15:0], 16'd0};
      end
      mr3k_pkg::OP_COP0: begin
        if (rs == mr3k_pkg::CO_MF) begin
          wb_en = 1'b1; wb_addr = rt; wb_data = c0v;
        end else if (rs == mr3k_pkg::CO_MT) begin
          if (rd == mr3k_pkg::C0_CAUSE) begin
            c0_we_ex    = 1'b1;
            c0_wdata_ex = (c0v & ~mr3k_pkg::CAUSE_WR_MASK) | (t & mr3k_pkg::CAUSE_WR_MASK);
          end else if (rd != mr3k_pkg::C0_R6 && rd != mr3k_pkg::C0_BADVADDR &&
                       rd != mr3k_pkg::C0_EPC && rd != mr3k_pkg::C0_PRID) begin
            c0_we_ex = 1'b1;
          end
        end else if (rs == mr3k_pkg::CO_CO && fn == mr3k_pkg::FN_RFE) begin
          // Pop the interrupt/mode stack; the old pair in bits 5:4 stays.
          c0_we_ex    = 1'b1;
          c0_wdata_ex = {c0v[31:4], c0v[5:2]};
        end else begin
          ex_status_unimpl = 1'b1;
        end
      end
      mr3k_pkg::OP_LW: begin
        if (rt != mr3k_pkg::GPR_ZERO) begin
          ex_rd   = 1'b1;
          ex_addr = ea;
        end
      end
      mr3k_pkg::OP_SW: begin
        ex_wr    = 1'b1;
        ex_addr  = ea;
        ex_wdata = t;
      end
      default: ex_status_unimpl = 1'b1;
    endcase
  end

  // Register file write port: a load completes at its own accept; everything else in S_EXEC.
  logic          gpr_we;
  logic [AW-1:0] gpr_waddr;
  logic [31:0]   gpr_wdata;

  always_comb begin
    if (load_done) begin
      gpr_we    = 1'b1;
      gpr_waddr = load_dest;
      gpr_wdata = load_data;
    end else begin
      gpr_we    = (state == S_EXEC) && wb_en && (wb_addr != mr3k_pkg::GPR_ZERO);
      gpr_waddr = AW'(wb_addr);
      gpr_wdata = wb_data;
    end
  end

  logic c0_we;
  assign c0_we = (state == S_EXEC) && c0_we_ex;

  // Both read ports of the register file are copies kept in step by the same write.
  mr3k_ram #(.WIDTH(32), .DEPTH(GPR_COUNT)) u_gpr_s (
    .clk  (clk),
    .we   (gpr_we),
    .waddr(gpr_waddr),
    .wdata(gpr_wdata),
    .raddr(AW'(in_rs)),
    .rdata(gpr_q_s)
  );

  mr3k_ram #(.WIDTH(32), .DEPTH(GPR_COUNT)) u_gpr_t (
    .clk  (clk),
    .we   (gpr_we),
    .waddr(gpr_waddr),
    .wdata(gpr_wdata),
    .raddr(AW'(instr_word[20:16])),
    .rdata(gpr_q_t)
  );

  logic [CW-1:0] c0_raddr;
  assign c0_raddr = (instr_word[31:26] == mr3k_pkg::OP_COP0 && in_rs == mr3k_pkg::CO_CO)
                    ? CW'(mr3k_pkg::C0_SR) : CW'(in_rd);

  mr3k_ram #(.WIDTH(32), .DEPTH(mr3k_pkg::C0_COUNT)) u_c0 (
    .clk  (clk),
    .we   (c0_we),
    .waddr(c0_addr),
    .wdata(c0_wdata_ex),
    .raddr(c0_raddr),
    .rdata(c0_q)
  );

  mr3k_pkg::md_req_t md_req;
  logic        md_done;
  logic [31:0] md_hi;
  logic [31:0] md_lo;

  assign md_req.start     = (state == S_EXEC) && md_go;
  assign md_req.is_div    = md_div;
  assign md_req.is_signed = md_sgn;

  mr3k_muldiv u_md (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .a   (s),
    .b   (t),
    .done(md_done),
    .hi  (md_hi),
    .lo  (md_lo)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      boot_image_present <= 1'b1;
      pc                 <= mr3k_pkg::PC_RESET;
      npc                <= mr3k_pkg::PC_RESET + 32'd4;
      hi                 <= '0;
      lo                 <= '0;
      load_pending       <= 1'b0;
      load_dest          <= '0;
      retired_count      <= '0;
      gpr_valid          <= '0;
      c0_valid           <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_write) begin
        boot_image_present <= cfg_data;
      end
      if (gpr_we) begin
        gpr_valid[gpr_waddr] <= 1'b1;
      end
      if (c0_we) begin
        c0_valid[c0_addr] <= 1'b1;
      end
      // A new result replaces the one being taken in the same cycle.
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!boot_image_present || (kind != load_pending)) begin
              state <= S_DONE;
            end else if (kind) begin
              load_pending <= 1'b0;
              state        <= S_DONE;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          pc            <= pc_n;
          npc           <= npc_n;
          retired_count <= retired_count + 64'd1;
          if (!ex_status_unimpl) begin
            if (hi_we) hi <= s;
            if (lo_we) lo <= s;
            if (ex_rd) begin
              load_pending <= 1'b1;
              load_dest    <= AW'(rt);
            end
          end
          state <= (md_go && !ex_status_unimpl) ? S_MD : S_DONE;
        end
        S_MD: begin
          if (md_done) begin
            hi    <= md_hi;
            lo    <= md_lo;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      instr   <= instr_word;
      rs_r    <= AW'(in_rs);
      rt_r    <= AW'(instr_word[20:16]);
      c0_addr <= c0_raddr;
      res_pc    <= pc;
      res_rd    <= 1'b0;
      res_wr    <= 1'b0;
      res_addr  <= '0;
      res_wdata <= '0;
      if (!boot_image_present) begin
        res_status <= mr3k_pkg::ST_NO_BOOT;
      end else if (kind != load_pending) begin
        res_status <= mr3k_pkg::ST_KIND;
      end else begin
        res_status <= mr3k_pkg::ST_OK;
      end
    end
    if (state == S_EXEC) begin
      res_pc <= pc_n;
      if (ex_status_unimpl) begin
        res_status <= mr3k_pkg::ST_UNIMPL;
      end else begin
        res_rd    <= ex_rd;
        res_wr    <= ex_wr;
        res_addr  <= ex_addr;
        res_wdata <= ex_wdata;
      end
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status    <= res_status;
      fetch_pc  <= res_pc;
      mem_read  <= res_rd;
      mem_write <= res_wr;
      mem_addr  <= res_addr;
      mem_wdata <= res_wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mr3k_checker.sv =====
`default_nettype none

module mr3k_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [31:0] fetch_pc,
  input wire logic        mem_read,
  input wire logic        mem_write
);

  // A stalled result holds its fetch address.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fetch_pc))
    else $error("result changed while stalled");

  // A refused or unimplemented item never requests memory.
  a_no_mem_on_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mr3k_pkg::ST_OK |-> !mem_read && !mem_write)
    else $error("memory request on a failed transaction");

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(mem_read && mem_write))
    else $error("read and write requested together");

  // The block works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind mips_r3000_instruction_execute mr3k_checker u_mr3k_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .status   (status),
  .fetch_pc (fetch_pc),
  .mem_read (mem_read),
  .mem_write(mem_write)
);

`default_nettype wire

// ===== dv/mips_r3000_instruction_execute_tb.sv =====
`default_nettype none

module mips_r3000_instruction_execute_tb;
  import mr3k_pkg::*;

  // One result of the core: the next fetch address plus any data-memory request.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] fetch_pc;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
  } core_result_t;

  // Architectural shadow of the core. It executes each accepted transaction and
  // queues the result that the core must produce for it.
  class core_scoreboard;
    logic [31:0] gpr [32];
    logic [31:0] cp0 [32];
    logic [31:0] pc, npc, hi, lo;
    logic        ld_busy;
    logic [4:0]  ld_reg;
    logic        boot_ok;
    int          errors;
    core_result_t pending_q[$];

    function void reset_arch();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (cp0[i]) cp0[i] = '0;
      gpr[REG_SP] = SP_RESET_VALUE;
      cp0[C0_SR] = C0_STATUS_INIT;
      cp0[C0_PRID] = C0_PRID_INIT;
      pc = PC_RESET;
      npc = PC_RESET + 32'd4;
      hi = '0;
      lo = '0;
      ld_busy = 1'b0;
      ld_reg = '0;
      boot_ok = 1'b1;
      errors = 0;
    endfunction

    function void set_reg(logic [4:0] r, logic [31:0] v);
      if (r != GPR_ZERO) gpr[r] = v;
    endfunction

    function logic slt_signed(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
    endfunction

    // Runs one instruction word and returns its result; pc/npc are already advanced.
    function core_result_t run_instr(logic [31:0] w);
      core_result_t r;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sa;
      logic [31:0] s, t, simm, zimm, jt;
      logic [63:0] prod;
      r = '0;
      op = w[31:26];
      fn = w[5:0];
      rs = w[25:21];
      rt = w[20:16];
      rd = w[15:11];
      sa = w[10:6];
      s = gpr[rs];
      t = gpr[rt];
      zimm = {16'h0, w[15:0]};
      simm = {{16{w[15]}}, w[15:0]};
      jt = (pc & JUMP_REGION) | {4'h0, w[25:0], 2'b00};
      r.status = ST_OK;
      case (op)
        OP_SPECIAL: begin
          case (fn)
            FN_SLL:   set_reg(rd, t << sa);
            FN_SRL:   set_reg(rd, t >> sa);
            FN_SRA:   set_reg(rd, $signed(t) >>> sa);
            FN_SLLV:  set_reg(rd, t << s[4:0]);
            FN_SRLV:  set_reg(rd, t >> s[4:0]);
            FN_SRAV:  set_reg(rd, $signed(t) >>> s[4:0]);
            FN_JR:    npc = s;
            FN_JALR: begin
              set_reg(rd, npc);
              npc = s;
            end
            FN_MFHI:  set_reg(rd, hi);
            FN_MTHI:  hi = s;
            FN_MFLO:  set_reg(rd, lo);
            FN_MTLO:  lo = s;
            FN_MULT: begin
              prod = $signed({{32{s[31]}}, s}) * $signed({{32{t[31]}}, t});
              lo = prod[31:0];
              hi = prod[63:32];
            end
            FN_MULTU: begin
              prod = {32'h0, s} * {32'h0, t};
              lo = prod[31:0];
              hi = prod[63:32];
            end
            FN_DIV: begin
              // Divide by zero and the one overflowing quotient have fixed answers.
              if (t == '0) begin
                lo = s[31] ? 32'd1 : 32'hFFFF_FFFF;
                hi = s;
              end else if (s == 32'h8000_0000 && t == 32'hFFFF_FFFF) begin
                lo = 32'h8000_0000;
                hi = '0;
              end else begin
                lo = $signed(s) / $signed(t);
                hi = $signed(s) % $signed(t);
              end
            end
            FN_DIVU: begin
              if (t == '0) begin
                lo = 32'hFFFF_FFFF;
                hi = s;
              end else begin
                lo = s / t;
                hi = s % t;
              end
            end
            FN_ADD, FN_ADDU: set_reg(rd, s + t);
            FN_SUB, FN_SUBU: set_reg(rd, s - t);
            FN_AND:  set_reg(rd, s & t);
            FN_OR:   set_reg(rd, s | t);
            FN_XOR:  set_reg(rd, s ^ t);
            FN_NOR:  set_reg(rd, ~(s | t));
            FN_SLT:  set_reg(rd, {31'h0, slt_signed(s, t)});
            FN_SLTU: set_reg(rd, {31'h0, s < t});
            default: r.status = ST_UNIMPL;
          endcase
        end
        OP_J: npc = jt;
        OP_JAL: begin
          set_reg(REG_RA, npc);
          npc = jt;
        end
        OP_BEQ: if (s == t) npc = pc + (simm << 2);
        OP_BNE: if (s != t) npc = pc + (simm << 2);
        OP_ADDI, OP_ADDIU: set_reg(rt, s + simm);
        OP_SLTI:  set_reg(rt, {31'h0, slt_signed(s, simm)});
        OP_SLTIU: set_reg(rt, {31'h0, s < simm});
        OP_ANDI:  set_reg(rt, s & zimm);
        OP_ORI:   set_reg(rt, s | zimm);
        OP_XORI:  set_reg(rt, s ^ zimm);
        OP_LUI:   set_reg(rt, {w[15:0], 16'h0});
        OP_COP0: begin
          if (rs == CO_MF) begin
            set_reg(rt, cp0[rd]);
          end else if (rs == CO_MT) begin
            // Some system registers are read-only and Cause only takes its two soft bits.
            if (rd == C0_CAUSE)
              cp0[rd] = (cp0[rd] & ~CAUSE_WR_MASK) | (t & CAUSE_WR_MASK);
            else if (!(rd inside {C0_R6, C0_BADVADDR, C0_EPC, C0_PRID}))
              cp0[rd] = t;
          end else if (rs == CO_CO && fn == FN_RFE) begin
            cp0[C0_SR] = {cp0[C0_SR][31:4], cp0[C0_SR][5:2]};
          end else begin
            r.status = ST_UNIMPL;
          end
        end
        OP_LW: begin
          // A load to register zero issues no read at all.
          if (rt != GPR_ZERO) begin
            r.mem_read = 1'b1;
            r.mem_addr = s + simm;
            ld_busy = 1'b1;
            ld_reg = rt;
          end
        end
        OP_SW: begin
          r.mem_write = 1'b1;
          r.mem_addr = s + simm;
          r.mem_wdata = t;
        end
        default: r.status = ST_UNIMPL;
      endcase
      return r;
    endfunction

    function void note_accepted(logic k, logic [31:0] w, logic [31:0] d);
      core_result_t r;
      r = '0;
      if (!boot_ok) begin
        r.status = ST_NO_BOOT;
      end else if (k) begin
        if (ld_busy) begin
          set_reg(ld_reg, d);
          ld_busy = 1'b0;
        end else begin
          r.status = ST_KIND;
        end
      end else if (ld_busy) begin
        r.status = ST_KIND;
      end else begin
        pc = npc;
        npc = pc + 32'd4;
        r = run_instr(w);
      end
      r.fetch_pc = pc;
      pending_q.push_back(r);
    endfunction

    function void check_result(core_result_t got);
      core_result_t exp;
      if (pending_q.size() == 0) begin
        $error("result with no transaction waiting: %p", got);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.fetch_pc !== exp.fetch_pc) begin
        $error("fetch_pc: expected %h, got %h", exp.fetch_pc, got.fetch_pc);
        errors++;
      end
      if (got.mem_read !== exp.mem_read) begin
        $error("mem_read: expected %0b, got %0b", exp.mem_read, got.mem_read);
        errors++;
      end
      if (got.mem_write !== exp.mem_write) begin
        $error("mem_write: expected %0b, got %0b", exp.mem_write, got.mem_write);
        errors++;
      end
      if (got.mem_addr !== exp.mem_addr) begin
        $error("mem_addr: expected %h, got %h", exp.mem_addr, got.mem_addr);
        errors++;
      end
      if (got.mem_wdata !== exp.mem_wdata) begin
        $error("mem_wdata: expected %h, got %h", exp.mem_wdata, got.mem_wdata);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [31:0] instr_word;
  logic [31:0] load_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [31:0] fetch_pc;
  logic        mem_read;
  logic        mem_write;
  logic [31:0] mem_addr;
  logic [31:0] mem_wdata;

  // Percent chances that each side holds off in a given cycle.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  core_scoreboard sb;

  mips_r3000_instruction_execute u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .instr_word (instr_word),
    .load_data  (load_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .fetch_pc   (fetch_pc),
    .mem_read   (mem_read),
    .mem_write  (mem_write),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run must never hang: a correct run needs far less than this.
  initial begin
    #20000000;
    $display("FAIL mips_r3000_instruction_execute");
    $finish;
  end

  // Every handshake at a rising edge: inputs go to the shadow model, outputs to the check.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_accepted(kind, instr_word, load_data);
    if (!rst && out_valid && out_ready)
      sb.check_result({status, fetch_pc, mem_read, mem_write, mem_addr, mem_wdata});
  end

  // The receiver stalls at random; the ready level changes only on falling edges.
  always @(negedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Presents one transaction and holds it until the core accepts it. Valid stays high
  // into the next transaction unless the sender idles; drain() lowers it at the end.
  task automatic send_item(input logic k, input logic [31:0] w, input logic [31:0] d);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    instr_word <= w;
    load_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits for every outstanding result, then lets the core go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // The boot flag is only written while the core is idle.
  task automatic write_boot_flag(input logic v);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.boot_ok = v;
  endtask

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sa);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Picks a plausible instruction, mostly implemented ones with random operands.
  function automatic logic [31:0] random_instr();
    logic [5:0] fns [26];
    logic [5:0] ops [15];
    logic [31:0] w;
    int unsigned pick;
    fns = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR, FN_MFHI,
            FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU,
            FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    ops = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI,
            OP_ORI, OP_XORI, OP_LUI, OP_COP0, OP_LW, OP_SW};
    w = $urandom;
    pick = $urandom_range(99);
    if (pick < 40) begin
      w[31:26] = OP_SPECIAL;
      w[5:0] = fns[$urandom_range(25)];
    end else if (pick < 95) begin
      w[31:26] = ops[$urandom_range(14)];
      if (w[31:26] == OP_COP0) begin
        case ($urandom_range(3))
          0: w[25:21] = CO_MF;
          1: w[25:21] = CO_MT;
          2: begin
            w[25:21] = CO_CO;
            w[5:0] = FN_RFE;
          end
          default: ;
        endcase
      end
    end
    return w;
  endfunction

  // Random program: a load is mostly followed by its data, sometimes by a stray word.
  task automatic random_phase(input int n);
    logic [31:0] w;
    for (int i = 0; i < n; i++) begin
      w = random_instr();
      send_item(($urandom_range(19) == 0), w, $urandom);
      if (w[31:26] == OP_LW && $urandom_range(9) != 0)
        send_item(1'b1, $urandom, $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_arch();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 1'b1;
    in_valid = 1'b0;
    kind = 1'b0;
    instr_word = '0;
    load_data = '0;
    out_ready = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: operand extremes, every special case, and the boot flag.
    write_boot_flag(1'b1);
    send_item(1'b0, itype(OP_LUI, 5'd0, 5'd1, 16'h8000), '0);
    send_item(1'b0, itype(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF), '0);
    send_item(1'b0, rtype(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0), '0);
    send_item(1'b0, rtype(FN_MFLO, 5'd0, 5'd0, 5'd3, 5'd0), '0);
    send_item(1'b0, rtype(FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0), '0);
    send_item(1'b0, rtype(FN_DIVU, 5'd2, 5'd0, 5'd0, 5'd0), '0);
    send_item(1'b0, rtype(FN_MFHI, 5'd0, 5'd0, 5'd4, 5'd0), '0);
    send_item(1'b0, rtype(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0), '0);
    send_item(1'b0, rtype(FN_SRA, 5'd0, 5'd1, 5'd5, 5'd31), '0);
    send_item(1'b0, {OP_COP0, CO_MT, 5'd2, C0_CAUSE, 11'h0}, '0);
    send_item(1'b0, {OP_COP0, CO_MT, 5'd2, C0_PRID, 11'h0}, '0);
    send_item(1'b0, {OP_COP0, CO_MF, 5'd6, C0_CAUSE, 11'h0}, '0);
    send_item(1'b0, {OP_COP0, CO_CO, 15'h0, FN_RFE}, '0);
    send_item(1'b0, {OP_COP0, 5'h01, 21'h0}, '0);
    send_item(1'b0, 32'hFFFF_FFFF, '0);
    send_item(1'b0, itype(OP_LW, REG_SP, 5'd0, 16'h8000), '0);
    send_item(1'b0, itype(OP_LW, REG_SP, 5'd7, 16'h7FFC), '0);
    send_item(1'b0, '0, '0);
    send_item(1'b1, '0, 32'hFFFF_FFFF);
    send_item(1'b1, '0, '0);
    send_item(1'b0, itype(OP_SW, REG_SP, 5'd7, 16'h0004), '0);
    send_item(1'b0, itype(OP_BEQ, 5'd0, 5'd0, 16'h8000), '0);
    send_item(1'b0, {OP_JAL, 26'h3FF_FFFF}, '0);
    write_boot_flag(1'b0);
    send_item(1'b0, 32'hFFFF_FFFF, '0);
    send_item(1'b1, '0, '0);
    write_boot_flag(1'b1);

    // Random part in three idling regimes.
    send_gap_pct = 36;
    recv_stall_pct = 69;
    random_phase(330);
    write_boot_flag(1'b0);
    random_phase(15);
    write_boot_flag(1'b1);
    send_gap_pct = 69;
    recv_stall_pct = 36;
    random_phase(330);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    random_phase(330);

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS mips_r3000_instruction_execute");
    end else begin
      $display("FAIL mips_r3000_instruction_execute");
    end
    $finish;
  end

endmodule

`default_nettype wire
